@@ rtl/setr_pkg.sv @@
package setr_pkg;

    // sample and level widths
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int LEVEL_W     = SAMPLE_BITS + FRAC_BITS;
    localparam int HYST_W      = 7;
    localparam int SPEED_W     = 17;
    localparam int LEN_W       = 16;
    localparam int MODE_W      = 3;
    localparam int REQ_W       = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG   = 3'd4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SAMPLE      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START       = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REARM       = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REARM_LEVEL = 2'd3;

    // trigger modes
    localparam logic [MODE_W-1:0] MODE_FREE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO_RISE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO_FALL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIXED_RISE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIXED_FALL = 3'd4;

    // reset values
    localparam logic [MODE_W-1:0]      RST_MODE      = MODE_FREE;
    localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD = 12'd2048;
    localparam logic [SPEED_W-1:0]     RST_SPEED     = 17'd131;
    localparam logic [LEN_W-1:0]       RST_LENGTH    = 16'd128;
    localparam logic [LEN_W-1:0]       RST_PRETRIG   = 16'd64;
    localparam logic [HYST_W-1:0]      RST_HYST      = 7'd51;
    localparam logic [HYST_W-1:0]      HYST_MAX      = 7'd102;

    // unity coefficient in Q1.16
    localparam logic [SPEED_W-1:0] SPEED_ONE = 17'd65536;

    // divide by 40 as multiply by reciprocal: exact for 12-bit thresholds
    localparam int HYST_MUL_W = 12;
    localparam logic [HYST_MUL_W-1:0] HYST_MUL = 12'd3277;
    localparam int HYST_SHIFT = 17;

    // average update product widths
    localparam int DIFF_W  = LEVEL_W + 1;
    localparam int KS_W    = SPEED_W + 1;
    localparam int PROD_W  = DIFF_W + KS_W;
    localparam int STEP_W  = PROD_W - FRAC_BITS;
    localparam int CMPS_W  = SAMPLE_BITS + 2;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    typedef struct packed {
        logic [REQ_W-1:0]       req_type;
        logic [SAMPLE_BITS-1:0] sample;
    } req_word_t;

    typedef struct packed {
        logic                   capture_done;
        logic                   keep_going;
        logic                   has_fired;
        logic [SAMPLE_BITS-1:0] current_threshold;
    } res_word_t;

endpackage

@@ rtl/scope_edge_trigger_auto_level.sv @@
// Edge trigger for a 12-bit sample stream with a level that follows an exponential average.
// A start word loads the configuration into working copies, rearm words restart the search,
// and each sample word after the first updates the average, counts pretrigger and
// post-trigger samples and looks for a rise or fall through the hysteresis band. Every request
// word gives exactly one result word. The block takes one word per clock while res_stall is
// low: a word sits in the input register, the average update (one 29 x 18 bit multiply) and
// all compares are combinational on that register, and the result is held in the output
// register that drives res_valid. While a result waits to be taken the input register takes
// at most one more word, after which req_stall follows res_stall. The configuration port
// writes one register at a time; write it only while no word is in flight.
module scope_edge_trigger_auto_level #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  setr_pkg::req_word_t           req_word,
    output logic                          res_valid,
    input  logic                          res_stall,
    output setr_pkg::res_word_t           res_word,
    input  logic                          cfg_wr_en,
    input  logic [setr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [setr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import setr_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // configuration registers
    logic [MODE_W-1:0]      mode_cfg_reg;
    logic [SAMPLE_BITS-1:0] thr_cfg_reg;
    logic [SPEED_W-1:0]     speed_cfg_reg;
    logic [LEN_W-1:0]       len_cfg_reg;
    logic [LEN_W-1:0]       pre_cfg_reg;

    // working copies and trigger state
    logic [MODE_W-1:0]      w_mode_reg, w_mode_next;
    logic [SPEED_W-1:0]     w_speed_reg, w_speed_next;
    logic [LEN_W-1:0]       w_len_reg, w_len_next;
    logic [LEN_W-1:0]       w_pre_reg, w_pre_next;
    logic [SAMPLE_BITS-1:0] thr_reg, thr_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [HYST_W-1:0]      hyst_reg, hyst_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   first_reg, first_next;
    logic                   fired_reg, fired_next;
    logic                   armed_reg, armed_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;

    // handshake stages
    logic      in_valid_reg;
    req_word_t in_word_reg;
    logic      out_valid_reg;
    res_word_t out_word_reg;
    logic      out_free;
    logic      process;
    logic      done;

    // datapath
    logic [SPEED_W-1:0]           k_sat;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [KS_W-1:0]       k_s;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_rnd;
    logic signed [STEP_W-1:0]     step;
    logic signed [STEP_W-1:0]     level_sum;
    logic [LEVEL_W-1:0]           level_upd;
    logic [SAMPLE_BITS-1:0]       thr_upd;
    logic                         follows;
    logic                         rise_mode;
    logic                         fall_mode;
    logic [COUNT_BITS-1:0]        cnt_inc;
    logic signed [CMPS_W-1:0]     lo, hi, s_s, p_s;
    logic                         arm_now;
    logic                         armed_mid;
    logic                         fire;
    logic [SAMPLE_BITS+HYST_MUL_W-1:0] hyst_prod;

    // handshake control
    assign out_free  = !out_valid_reg || !res_stall;
    assign process   = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_word_reg <= req_word;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg  <= RST_MODE;
            thr_cfg_reg   <= RST_THRESHOLD;
            speed_cfg_reg <= RST_SPEED;
            len_cfg_reg   <= RST_LENGTH;
            pre_cfg_reg   <= RST_PRETRIG;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE:      mode_cfg_reg  <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD: thr_cfg_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_SPEED:     speed_cfg_reg <= cfg_data[SPEED_W-1:0];
                CFG_LENGTH:    len_cfg_reg   <= cfg_data[LEN_W-1:0];
                CFG_PRETRIG:   pre_cfg_reg   <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // average update: level + ((x<<16 - level) * k + half) >> 16
    assign k_sat     = (w_speed_reg > SPEED_ONE) ? SPEED_ONE : w_speed_reg;
    assign diff      = $signed({1'b0, in_word_reg.sample, {FRAC_BITS{1'b0}}})
                     - $signed({1'b0, level_reg});
    assign k_s       = $signed({1'b0, k_sat});
    assign prod      = diff * k_s;
    assign prod_rnd  = prod + $signed(ROUND_HALF);
    assign step      = prod_rnd[PROD_W-1:FRAC_BITS];
    assign level_sum = $signed({{(STEP_W-LEVEL_W){1'b0}}, level_reg}) + step;
    assign level_upd = level_sum[LEVEL_W-1:0];

    // mode decode
    assign rise_mode = (w_mode_reg == MODE_AUTO_RISE) || (w_mode_reg == MODE_FIXED_RISE);
    assign fall_mode = (w_mode_reg == MODE_AUTO_FALL) || (w_mode_reg == MODE_FIXED_FALL);
    assign follows   = !(w_mode_reg == MODE_FIXED_RISE) && !(w_mode_reg == MODE_FIXED_FALL);
    assign thr_upd   = follows ? level_upd[LEVEL_W-1:FRAC_BITS] : thr_reg;

    // saturating counter
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNT_BITS'(1);

    // hysteresis band edges, signed so a low threshold may go below zero
    assign lo  = $signed({2'b00, thr_upd}) - $signed({{(CMPS_W-HYST_W){1'b0}}, hyst_reg});
    assign hi  = $signed({2'b00, thr_upd}) + $signed({{(CMPS_W-HYST_W){1'b0}}, hyst_reg});
    assign s_s = $signed({2'b00, in_word_reg.sample});
    assign p_s = $signed({2'b00, prev_reg});

    // edge search: arm on one crossing, fire on the opposite one; any other mode fires at once
    always_comb
    begin
        arm_now   = 1'b0;
        armed_mid = armed_reg;
        fire      = 1'b0;
        if (rise_mode)
        begin
            arm_now   = !armed_reg && (p_s > lo) && (s_s <= lo);
            armed_mid = armed_reg || arm_now;
            fire      = armed_mid && (p_s < hi) && (s_s >= hi);
        end
        else if (fall_mode)
        begin
            arm_now   = !armed_reg && (p_s < hi) && (s_s >= hi);
            armed_mid = armed_reg || arm_now;
            fire      = armed_mid && (p_s > lo) && (s_s <= lo);
        end
        else
        begin
            fire = 1'b1;
        end
    end

    // threshold / 40 for the hysteresis band
    assign hyst_prod = SAMPLE_BITS'(thr_cfg_reg) * HYST_MUL;

    // next state for one word
    always_comb
    begin
        w_mode_next  = w_mode_reg;
        w_speed_next = w_speed_reg;
        w_len_next   = w_len_reg;
        w_pre_next   = w_pre_reg;
        thr_next     = thr_reg;
        level_next   = level_reg;
        hyst_next    = hyst_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        fired_next   = fired_reg;
        armed_next   = armed_reg;
        cnt_next     = cnt_reg;
        done         = 1'b0;
        case (in_word_reg.req_type)
            REQ_SAMPLE:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    prev_next  = in_word_reg.sample;
                end
                else
                begin
                    level_next = level_upd;
                    thr_next   = thr_upd;
                    if (fired_reg)
                    begin
                        cnt_next = cnt_inc;
                        done     = CMP_W'(cnt_inc) >= CMP_W'(w_len_reg);
                    end
                    else if (CMP_W'(cnt_reg) < CMP_W'(w_pre_reg))
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        prev_next  = in_word_reg.sample;
                        armed_next = armed_mid && !fire;
                        fired_next = fire;
                    end
                end
            end
            REQ_START:
            begin
                w_mode_next  = mode_cfg_reg;
                w_speed_next = speed_cfg_reg;
                w_len_next   = len_cfg_reg;
                w_pre_next   = pre_cfg_reg;
                thr_next     = thr_cfg_reg;
                hyst_next    = hyst_prod[HYST_SHIFT +: HYST_W];
                level_next   = {thr_cfg_reg, {FRAC_BITS{1'b0}}};
                first_next   = 1'b1;
                fired_next   = 1'b0;
                armed_next   = 1'b0;
                cnt_next     = '0;
                prev_next    = thr_cfg_reg;
            end
            REQ_REARM:
            begin
                fired_next = 1'b0;
                armed_next = 1'b0;
                cnt_next   = '0;
                prev_next  = thr_reg;
            end
            default:
            begin
                first_next = 1'b1;
                level_next = {thr_reg, {FRAC_BITS{1'b0}}};
                fired_next = 1'b0;
                armed_next = 1'b0;
                cnt_next   = '0;
                prev_next  = thr_reg;
            end
        endcase
    end

    // trigger state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_mode_reg  <= RST_MODE;
            w_speed_reg <= RST_SPEED;
            w_len_reg   <= RST_LENGTH;
            w_pre_reg   <= RST_PRETRIG;
            thr_reg     <= RST_THRESHOLD;
            level_reg   <= {RST_THRESHOLD, {FRAC_BITS{1'b0}}};
            hyst_reg    <= RST_HYST;
            prev_reg    <= RST_THRESHOLD;
            first_reg   <= 1'b1;
            fired_reg   <= 1'b0;
            armed_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (process)
        begin
            w_mode_reg  <= w_mode_next;
            w_speed_reg <= w_speed_next;
            w_len_reg   <= w_len_next;
            w_pre_reg   <= w_pre_next;
            thr_reg     <= thr_next;
            level_reg   <= level_next;
            hyst_reg    <= hyst_next;
            prev_reg    <= prev_next;
            first_reg   <= first_next;
            fired_reg   <= fired_next;
            armed_reg   <= armed_next;
            cnt_reg     <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_word_reg.capture_done      <= done;
            out_word_reg.keep_going        <= !done;
            out_word_reg.has_fired         <= fired_next;
            out_word_reg.current_threshold <= thr_next;
        end
    end

    // a finished capture must have fired
    a_done_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.capture_done |-> out_word_reg.has_fired)
        else $error("capture done without trigger");

    // a start word clears the search and waits for a first sample
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        process && (in_word_reg.req_type == REQ_START)
        |=> first_reg && !fired_reg && !armed_reg && (cnt_reg == '0))
        else $error("start did not clear trigger state");

    // hysteresis band stays within threshold / 40 of a 12-bit value
    a_hyst_range: assert property (@(posedge clk) disable iff (!rst_n)
        hyst_reg <= HYST_MAX)
        else $error("hysteresis band out of range");

    // never armed and fired at once
    a_arm_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !(armed_reg && fired_reg))
        else $error("armed while fired");

    // a word leaving the input register always lands in the result register
    a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid_reg)
        else $error("result word lost");

endmodule
